FILE: rtl/b64d_pkg.sv
// Package for the base64 stream decoder: status codes, character classes,
// decoded-symbol and result structures, and character constants.
// Depends on nothing; every other file of the decoder but the checker imports it.
`timescale 1ns / 1ps

package b64d_pkg;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_CHAR  = 3'd1,
    STATUS_AFTER_PAD = 3'd2,
    STATUS_PAD_OVER  = 3'd3,
    STATUS_NOT_MULT4 = 3'd4,
    STATUS_TOO_SHORT = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CLS_SYMBOL,
    CLS_BLANK,
    CLS_PAD,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [5:0]  value;
  } sym_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;
    status_e    status;
  } result_t;

  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] OFFS_UPPER   = 8'h41;
  localparam logic [7:0] OFFS_LOWER   = 8'h47;
  localparam logic [7:0] OFFS_DIGIT   = 8'hFC;
  localparam logic [5:0] SYM_PLUS     = 6'h3E;
  localparam logic [5:0] SYM_SLASH    = 6'h3F;
  localparam logic [2:0] MIN_RAW_LEN  = 3'd4;
  localparam logic [1:0] MAX_PAD      = 2'd3;

endpackage

FILE: rtl/b64d_sym_decode.sv
// Character classifier: maps one raw character to its class and, for an
// alphabet symbol, its six-bit value. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_sym_decode (
  input  logic          [7:0] in_char_i,
  output b64d_pkg::sym_t      sym_o
);
  import b64d_pkg::*;

  logic [7:0] diff;

  always_comb begin
    diff  = 8'h00;
    sym_o = '{cls: CLS_OTHER, value: 6'h00};
    case (in_char_i) inside
      [8'h41:8'h5A]: begin
        diff  = in_char_i - OFFS_UPPER;
        sym_o = '{cls: CLS_SYMBOL, value: diff[5:0]};
      end
      [8'h61:8'h7A]: begin
        diff  = in_char_i - OFFS_LOWER;
        sym_o = '{cls: CLS_SYMBOL, value: diff[5:0]};
      end
      [8'h30:8'h39]: begin
        diff  = in_char_i - OFFS_DIGIT;
        sym_o = '{cls: CLS_SYMBOL, value: diff[5:0]};
      end
      CHAR_PLUS:     sym_o = '{cls: CLS_SYMBOL, value: SYM_PLUS};
      CHAR_SLASH:    sym_o = '{cls: CLS_SYMBOL, value: SYM_SLASH};
      CHAR_PAD:      sym_o = '{cls: CLS_PAD, value: 6'h00};
      CHAR_SPACE,
      [8'h09:8'h0D]: sym_o = '{cls: CLS_BLANK, value: 6'h00};
      default:       sym_o = '{cls: CLS_OTHER, value: 6'h00};
    endcase
  end

endmodule

FILE: rtl/b64d_step.sv
// Message state of the decoder and the logic that turns one classified
// character into one result. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                last_char_i,
  input  b64d_pkg::sym_t      sym_i,
  output b64d_pkg::result_t   result_o
);
  import b64d_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [5:0] left_q, left_d;
  logic       pad_mode_q, pad_mode_d;
  logic [1:0] pad_cnt_q, pad_cnt_d;
  logic [2:0] raw_len_q, raw_len_d;
  status_e    err_q, err_d;

  logic [7:0] byte_val;
  logic       byte_ok;
  logic [1:0] group_sum;
  status_e    status;

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    pad_mode_d = pad_mode_q;
    pad_cnt_d  = pad_cnt_q;
    err_d      = err_q;
    byte_val   = 8'h00;
    byte_ok    = 1'b0;
    raw_len_d  = (raw_len_q < MIN_RAW_LEN) ? raw_len_q + 3'd1 : raw_len_q;

    if (err_q == STATUS_OK) begin
      if (!pad_mode_q) begin
        case (sym_i.cls)
          CLS_SYMBOL: begin
            case (phase_q)
              2'd1: begin
                byte_val = {left_q, sym_i.value[5:4]};
                byte_ok  = 1'b1;
              end
              2'd2: begin
                byte_val = {left_q[3:0], sym_i.value[5:2]};
                byte_ok  = 1'b1;
              end
              2'd3: begin
                byte_val = {left_q[1:0], sym_i.value};
                byte_ok  = 1'b1;
              end
              default: ;
            endcase
            left_d  = sym_i.value;
            phase_d = phase_q + 2'd1;
          end
          CLS_BLANK: ;
          CLS_PAD: begin
            pad_mode_d = 1'b1;
            pad_cnt_d  = 2'd1;
          end
          default: err_d = STATUS_BAD_CHAR;
        endcase
      end else begin
        case (sym_i.cls)
          CLS_PAD: begin
            if (pad_cnt_q >= MAX_PAD) begin
              err_d = STATUS_PAD_OVER;
            end else begin
              pad_cnt_d = pad_cnt_q + 2'd1;
            end
          end
          CLS_BLANK: ;
          default: err_d = STATUS_AFTER_PAD;
        endcase
      end
    end

    if (err_d != STATUS_OK) begin
      byte_ok  = 1'b0;
      byte_val = 8'h00;
    end

    group_sum = phase_d + pad_cnt_d;
    status    = STATUS_OK;
    if (last_char_i) begin
      if (raw_len_d < MIN_RAW_LEN) begin
        status = STATUS_TOO_SHORT;
      end else if (err_d != STATUS_OK) begin
        status = err_d;
      end else if (group_sum != 2'd0) begin
        status = STATUS_NOT_MULT4;
      end
    end

    result_o = '{out_byte: byte_val, byte_valid: byte_ok,
                 end_of_message: last_char_i, status: status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 2'd0;
      left_q     <= 6'd0;
      pad_mode_q <= 1'b0;
      pad_cnt_q  <= 2'd0;
      raw_len_q  <= 3'd0;
      err_q      <= STATUS_OK;
    end else if (accept_i) begin
      if (last_char_i) begin
        phase_q    <= 2'd0;
        left_q     <= 6'd0;
        pad_mode_q <= 1'b0;
        pad_cnt_q  <= 2'd0;
        raw_len_q  <= 3'd0;
        err_q      <= STATUS_OK;
      end else begin
        phase_q    <= phase_d;
        left_q     <= left_d;
        pad_mode_q <= pad_mode_d;
        pad_cnt_q  <= pad_cnt_d;
        raw_len_q  <= raw_len_d;
        err_q      <= err_d;
      end
    end
  end

endmodule

FILE: rtl/b64d_out_reg.sv
// Result register of the decoder: holds one result until the consumer takes
// it and admits a new request in the same cycle. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  b64d_pkg::result_t result_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              free_o,
  output b64d_pkg::result_t result_o
);
  import b64d_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

FILE: rtl/base64_stream_decoder_core.sv
// Top level of the base64 stream decoder: classifier, message state and
// result register. Depends on b64d_pkg, b64d_sym_decode, b64d_step, b64d_out_reg.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_ready_o | in_char_i, last_char_i
//   out     | output    | out_valid_o/out_ready_i | out_byte_o, byte_valid_o,
//           |           |                      | end_of_message_o, status_o
//
// Each request yields one result in the cycle after acceptance; one request is
// accepted per cycle while results are taken, set by the single result register.
// Reset clears the message state and empties the result register.
// While the result register is full and not taken, in_ready_o is low.
`timescale 1ns / 1ps

module base64_stream_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_message_o,
  output logic [2:0] status_o
);
  import b64d_pkg::*;

  sym_t    sym;
  result_t step_res;
  result_t out_res;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  b64d_sym_decode u_sym (
    .in_char_i (in_char_i),
    .sym_o     (sym)
  );

  b64d_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .last_char_i (last_char_i),
    .sym_i       (sym),
    .result_o    (step_res)
  );

  b64d_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (step_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (in_ready_o),
    .result_o    (out_res)
  );

  assign out_byte_o       = out_res.out_byte;
  assign byte_valid_o     = out_res.byte_valid;
  assign end_of_message_o = out_res.end_of_message;
  assign status_o         = out_res.status;

endmodule

FILE: rtl/b64d_checker.sv
// Port-level checks for the base64 stream decoder, attached to the top level
// by the bind statement at the end. Depends on base64_stream_decoder_core.
`timescale 1ns / 1ps

module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       last_char_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       end_of_message_o,
  input logic [2:0] status_o
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(status_o) && $stable(end_of_message_o))
    else $error("stalled result changed");

  // Only the end-of-message result carries a status.
  a_status_eom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_message_o |-> status_o == 3'd0)
    else $error("status on a result that is not the last");

  // A result without a byte shows a zero byte.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == 8'h00)
    else $error("byte present without byte_valid");

  // An empty result register never blocks the input.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // The end-of-message flag follows the accepted request.
  a_eom_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o
      && end_of_message_o == $past(last_char_i))
    else $error("result does not follow accepted request");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (.*);
